/* rtl/vv_pkg.sv */
// ----------------------------------------------------------------------------
// vv_pkg: shared types, constants and helpers for the Verlet atom update
// Register indexes, reset values, fixed-point widths and saturation.
// ----------------------------------------------------------------------------
package vv_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned NUM_TYPES = 4;
  localparam int unsigned INDEX_W   = 3;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [INDEX_W-1:0] REG_INV_MASS0 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_INV_MASS1 = 3'd2;
  localparam logic [INDEX_W-1:0] REG_INV_MASS2 = 3'd3;
  localparam logic [INDEX_W-1:0] REG_INV_MASS3 = 3'd4;

  // Reset values: dt of 328/65536, unit reciprocal mass
  localparam logic [DT_W-1:0]   TIME_STEP_RST = 16'd328;
  localparam logic [WORD_W-1:0] INV_MASS_RST  = 32'd65536;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic {
    KIND_INITIAL = 1'b0,  // kick then drift
    KIND_FINAL   = 1'b1   // kick only
  } kind_t;

  typedef logic [NUM_TYPES-1:0][WORD_W-1:0] inv_mass_tbl_t;

  // Clamp a 48-bit signed value to 32 bits
  function automatic logic signed [31:0] sat48(input logic signed [47:0] a);
    logic fits;
    fits = (a[47:31] == {17{a[47]}});
    if (fits) begin
      return a[31:0];
    end else if (a[47]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  // Clamp a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] a);
    logic fits;
    fits = (a[32] == a[31]);
    if (fits) begin
      return a[31:0];
    end else if (a[32]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

/* rtl/velocity_verlet_atom_update.sv */
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update: fixed-point Velocity Verlet update of one atom
// Three component lanes behind a shared register file and valid pipeline.
// ----------------------------------------------------------------------------
// One atom request is taken per clock whenever start is high and busy is low;
// busy is high only during reset. Each request yields one result, shown for a
// single cycle with done high after the five stages: the two kick multiplies,
// the velocity add, the drift multiply and the position add, each closed by a
// register. Results cannot be held off, so the throughput is one atom per
// clock. Configuration writes are always ready and must only be issued while
// no atom is in flight.
module velocity_verlet_atom_update
  import vv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [TYPE_W-1:0]         atom_type,
  input  logic signed [WORD_W-1:0]  pos_x,
  input  logic signed [WORD_W-1:0]  pos_y,
  input  logic signed [WORD_W-1:0]  pos_z,
  input  logic signed [WORD_W-1:0]  vel_x,
  input  logic signed [WORD_W-1:0]  vel_y,
  input  logic signed [WORD_W-1:0]  vel_z,
  input  logic signed [WORD_W-1:0]  force_x,
  input  logic signed [WORD_W-1:0]  force_y,
  input  logic signed [WORD_W-1:0]  force_z,
  // result
  output logic                      done,
  output logic signed [WORD_W-1:0]  new_pos_x,
  output logic signed [WORD_W-1:0]  new_pos_y,
  output logic signed [WORD_W-1:0]  new_pos_z,
  output logic signed [WORD_W-1:0]  new_vel_x,
  output logic signed [WORD_W-1:0]  new_vel_y,
  output logic signed [WORD_W-1:0]  new_vel_z,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [INDEX_W-1:0]        cfg_index,
  input  logic [WORD_W-1:0]         cfg_data
);

  localparam int unsigned DEPTH = 5;

  logic [DT_W-1:0]   time_step;
  inv_mass_tbl_t     inv_mass;
  logic [WORD_W-1:0] im_sel;
  kind_t             kind_in;
  logic              accept;
  logic [DEPTH-1:0]  valid_pipe;

  assign busy    = rst;
  assign accept  = start && !busy;
  assign kind_in = kind_t'(kind);
  assign im_sel  = inv_mass[atom_type];

  vv_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .time_step (time_step),
    .inv_mass  (inv_mass)
  );

  vv_lane u_lane_x (
    .clk (clk), .kind (kind_in), .time_step (time_step), .inv_mass (im_sel),
    .pos (pos_x), .vel (vel_x), .frc (force_x),
    .new_pos (new_pos_x), .new_vel (new_vel_x)
  );

  vv_lane u_lane_y (
    .clk (clk), .kind (kind_in), .time_step (time_step), .inv_mass (im_sel),
    .pos (pos_y), .vel (vel_y), .frc (force_y),
    .new_pos (new_pos_y), .new_vel (new_vel_y)
  );

  vv_lane u_lane_z (
    .clk (clk), .kind (kind_in), .time_step (time_step), .inv_mass (im_sel),
    .pos (pos_z), .vel (vel_z), .frc (force_z),
    .new_pos (new_pos_z), .new_vel (new_vel_z)
  );

  // Valid bits travel alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[DEPTH-2:0], accept};
    end
  end

  assign done = valid_pipe[DEPTH-1];

`ifndef NO_ASSERTIONS
  // Every request gives exactly one strobe, a fixed latency later
  assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, DEPTH))
    else $error("done strobe does not match request latency");

  // Zero time step leaves velocity untouched
  assert property (@(posedge clk) disable iff (rst)
    (done && (time_step == '0)) |-> (new_vel_x == $past(vel_x, DEPTH)))
    else $error("velocity changed with zero time step");

  // Zero time step leaves position untouched
  assert property (@(posedge clk) disable iff (rst)
    (done && (time_step == '0)) |-> (new_pos_y == $past(pos_y, DEPTH)))
    else $error("position changed with zero time step");

  // Final kind passes position through
  assert property (@(posedge clk) disable iff (rst)
    (done && ($past(kind, DEPTH) == KIND_FINAL)) |-> (new_pos_z == $past(pos_z, DEPTH)))
    else $error("final kind altered position");
`endif

endmodule

/* rtl/vv_regs.sv */
// ----------------------------------------------------------------------------
// vv_regs: configuration register file
// Holds the time step and the four per-type reciprocal masses.
// ----------------------------------------------------------------------------
module vv_regs
  import vv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [INDEX_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic [DT_W-1:0]      time_step,
  output inv_mass_tbl_t        inv_mass
);

  logic wr;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      inv_mass  <= {NUM_TYPES{INV_MASS_RST}};
    end else if (wr) begin
      case (cfg_index)
        REG_TIME_STEP: time_step   <= cfg_data[DT_W-1:0];
        REG_INV_MASS0: inv_mass[0] <= cfg_data;
        REG_INV_MASS1: inv_mass[1] <= cfg_data;
        REG_INV_MASS2: inv_mass[2] <= cfg_data;
        REG_INV_MASS3: inv_mass[3] <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A write past the register list changes nothing
  assert property (@(posedge clk) disable iff (rst)
    (wr && (cfg_index > REG_INV_MASS3)) |=> ($stable(time_step) && $stable(inv_mass)))
    else $error("out-of-range config write changed a register");
`endif

endmodule

/* rtl/vv_lane.sv */
// ----------------------------------------------------------------------------
// vv_lane: one Cartesian component of the kick and drift
// Five register stages: f*dt, a*invmass, velocity sum, v*dt, position sum.
// ----------------------------------------------------------------------------
module vv_lane
  import vv_pkg::*;
(
  input  logic                      clk,
  input  kind_t                     kind,
  input  logic [DT_W-1:0]           time_step,
  input  logic [WORD_W-1:0]         inv_mass,
  input  logic signed [WORD_W-1:0]  pos,
  input  logic signed [WORD_W-1:0]  vel,
  input  logic signed [WORD_W-1:0]  frc,
  output logic signed [WORD_W-1:0]  new_pos,
  output logic signed [WORD_W-1:0]  new_vel
);

  logic signed [DT_W:0]     dt_s;
  // stage 1
  logic signed [47:0]       prod_fd;
  logic signed [WORD_W-1:0] pos1, vel1;
  logic [WORD_W-1:0]        im1;
  kind_t                    kind1;
  // stage 2
  logic signed [30:0]       accel;
  logic signed [62:0]       prod_am;
  logic signed [WORD_W-1:0] pos2, vel2;
  kind_t                    kind2;
  // stage 3
  logic signed [46:0]       kick;
  logic signed [47:0]       vel_sum;
  logic signed [WORD_W-1:0] vel3, pos3;
  kind_t                    kind3;
  // stage 4
  logic signed [47:0]       prod_vd;
  logic signed [WORD_W-1:0] vel4, pos4;
  kind_t                    kind4;
  // stage 5
  logic signed [WORD_W-1:0] drift;
  logic signed [32:0]       pos_sum;

  assign dt_s = signed'({1'b0, time_step});

  // Stage 1: scaled force product, dt/2 taken as dt in Q0.17
  always_ff @(posedge clk) begin
    prod_fd <= 48'(frc) * 48'(dt_s);
    pos1    <= pos;
    vel1    <= vel;
    im1     <= inv_mass;
    kind1   <= kind;
  end

  // Stage 2: floor by 2^17, then times reciprocal mass
  assign accel = prod_fd[47:17];
  always_ff @(posedge clk) begin
    prod_am <= 63'(accel) * 63'(signed'({1'b0, im1}));
    pos2    <= pos1;
    vel2    <= vel1;
    kind2   <= kind1;
  end

  // Stage 3: floor by 2^16, velocity kick with saturation
  assign kick    = prod_am[62:16];
  assign vel_sum = 48'(vel2) + 48'(kick);
  always_ff @(posedge clk) begin
    vel3  <= sat48(vel_sum);
    pos3  <= pos2;
    kind3 <= kind2;
  end

  // Stage 4: drift product
  always_ff @(posedge clk) begin
    prod_vd <= 48'(vel3) * 48'(dt_s);
    vel4    <= vel3;
    pos4    <= pos3;
    kind4   <= kind3;
  end

  // Stage 5: floor by 2^16, position update, result register
  assign drift   = prod_vd[47:16];
  assign pos_sum = 33'(pos4) + 33'(drift);
  always_ff @(posedge clk) begin
    new_vel <= vel4;
    new_pos <= (kind4 == KIND_FINAL) ? pos4 : sat33(pos_sum);
  end

endmodule

/* sim/velocity_verlet_atom_update_tb.sv */
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update_tb: self-checking bench for the atom update
// Sends atom requests with random gaps. A local fixed-point predictor
// computes each expected kick/drift result, and every result is checked
// field by field in arrival order. Register settings change between
// phases, only while no request is in flight.
// ----------------------------------------------------------------------------
module velocity_verlet_atom_update_tb;
  import vv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;        // pipeline is five deep
  localparam int LIMIT_CYCLES = 400_000;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    kind_t                      kind;
    logic [TYPE_W-1:0]          atom_type;
    logic [2:0][WORD_W-1:0]     pos;
    logic [2:0][WORD_W-1:0]     vel;
    logic [2:0][WORD_W-1:0]     frc;
  } atom_req_t;

  typedef struct packed {
    logic [2:0][WORD_W-1:0]     pos;
    logic [2:0][WORD_W-1:0]     vel;
  } atom_result_t;

  // DUT signals
  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      kind;
  logic [TYPE_W-1:0]         atom_type;
  logic signed [WORD_W-1:0]  pos_x, pos_y, pos_z;
  logic signed [WORD_W-1:0]  vel_x, vel_y, vel_z;
  logic signed [WORD_W-1:0]  force_x, force_y, force_z;
  logic                      done;
  logic signed [WORD_W-1:0]  new_pos_x, new_pos_y, new_pos_z;
  logic signed [WORD_W-1:0]  new_vel_x, new_vel_y, new_vel_z;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [INDEX_W-1:0]        cfg_index;
  logic [WORD_W-1:0]         cfg_data;

  // Local copy of the register file
  logic [DT_W-1:0]           step_reg;
  logic [WORD_W-1:0]         inv_mass_reg [NUM_TYPES];

  atom_result_t              pending_q [$];
  int                        error_count;
  int                        cycle_count;
  string                     axis_name [3] = '{"x", "y", "z"};

  velocity_verlet_atom_update dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic logic [WORD_W-1:0] clamp_word(input longint a);
    if (a > 64'sd2147483647) return SAT_MAX;
    if (a < -64'sd2147483648) return SAT_MIN;
    return a[WORD_W-1:0];
  endfunction

  // Kick then optional drift, per component, with floor truncation
  function automatic atom_result_t predict_update(input atom_req_t req);
    atom_result_t res;
    longint dt, im, x, v, f, acc, kick, vn, xn;
    int c;
    dt = {48'd0, step_reg};
    im = {32'd0, inv_mass_reg[req.atom_type]};
    for (c = 0; c < 3; c++) begin
      x    = $signed(req.pos[c]);
      v    = $signed(req.vel[c]);
      f    = $signed(req.frc[c]);
      acc  = (f * dt) >>> 17;      // dt/2 as Q0.17
      kick = (acc * im) >>> 16;
      vn   = $signed(clamp_word(v + kick));
      xn   = x;
      if (req.kind == KIND_INITIAL) begin
        xn = $signed(clamp_word(x + ((vn * dt) >>> 16)));
      end
      res.pos[c] = xn[WORD_W-1:0];
      res.vel[c] = vn[WORD_W-1:0];
    end
    return res;
  endfunction

  // Result checker: one result per strobe, oldest expectation first
  always @(posedge clk) begin : check_results
    atom_result_t got, want;
    int c;
    if (!rst && done) begin
      got.pos = {new_pos_z, new_pos_y, new_pos_x};
      got.vel = {new_vel_z, new_vel_y, new_vel_x};
      if (pending_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = pending_q.pop_front();
        for (c = 0; c < 3; c++) begin
          if (got.pos[c] !== want.pos[c]) begin
            report_error($sformatf("new_pos_%s got %h expected %h",
                                   axis_name[c], got.pos[c], want.pos[c]));
          end
          if (got.vel[c] !== want.vel[c]) begin
            report_error($sformatf("new_vel_%s got %h expected %h",
                                   axis_name[c], got.vel[c], want.vel[c]));
          end
        end
      end
    end
  end

  // Request driver: hold start until the request is taken
  task automatic send_atom(input atom_req_t req);
    @(negedge clk);
    start     = 1'b1;
    kind      = req.kind;
    atom_type = req.atom_type;
    {pos_z, pos_y, pos_x}       = req.pos;
    {vel_z, vel_y, vel_x}       = req.vel;
    {force_z, force_y, force_x} = req.frc;
    do @(posedge clk); while (busy);
    pending_q.push_back(predict_update(req));
  endtask

  // Idle with start low and junk on kind, type and the x request fields
  task automatic pause_requests(input int n);
    if (n > 0) begin
      @(negedge clk);
      start     = 1'b0;
      kind      = 1'($urandom_range(1));
      atom_type = TYPE_W'($urandom_range(NUM_TYPES - 1));
      {pos_x, vel_x, force_x} = {$urandom, $urandom, $urandom};
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Wait until every outstanding request has produced its result
  task automatic drain_pipeline();
    pause_requests(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays up for back-to-back writes
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIME_STEP) begin
      step_reg = data[DT_W-1:0];
    end else if (idx >= REG_INV_MASS0 && idx <= REG_INV_MASS3) begin
      inv_mass_reg[TYPE_W'(idx - REG_INV_MASS0)] = data;
    end
  endtask

  task automatic write_done();
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom;
  endtask

  // Full register setting, applied only when the pipe is empty
  task automatic apply_setting(input logic [WORD_W-1:0] dt, input logic [WORD_W-1:0] m0,
                               input logic [WORD_W-1:0] m1, input logic [WORD_W-1:0] m2,
                               input logic [WORD_W-1:0] m3);
    drain_pipeline();
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_INV_MASS0, m0);
    write_reg(REG_INV_MASS1, m1);
    write_reg(REG_INV_MASS2, m2);
    write_reg(REG_INV_MASS3, m3);
    write_done();
  endtask

  function automatic atom_req_t build_atom(input kind_t k, input logic [TYPE_W-1:0] t,
                                           input logic [WORD_W-1:0] p,
                                           input logic [WORD_W-1:0] v,
                                           input logic [WORD_W-1:0] f);
    atom_req_t r;
    r.kind      = k;
    r.atom_type = t;
    r.pos       = {3{p}};
    r.vel       = {3{v}};
    r.frc       = {3{f}};
    return r;
  endfunction

  // Mix of full-range, small and boundary values
  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $urandom_range(524287) - 262144;
    if (sel == 8) begin
      case ($urandom_range(4))
        0: return SAT_MAX;
        1: return SAT_MIN;
        2: return '0;
        3: return '1;
        default: return 32'd1;
      endcase
    end
    return (SAT_MAX - $urandom_range(65535)) ^ {32{$urandom_range(1) == 1}};
  endfunction

  function automatic atom_req_t rand_atom();
    atom_req_t r;
    int c;
    r.kind      = kind_t'($urandom_range(1));
    r.atom_type = TYPE_W'($urandom_range(NUM_TYPES - 1));
    for (c = 0; c < 3; c++) begin
      r.pos[c] = rand_word();
      r.vel[c] = rand_word();
      r.frc[c] = rand_word();
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while bursting
  function automatic int pick_gap(input bit bursty);
    int unsigned r;
    if (bursty) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic run_random_phase(input int n);
    bit bursty;
    int i;
    bursty = 1'b0;
    for (i = 0; i < n; i++) begin
      if (i % 50 == 0) bursty = ($urandom_range(3) == 0);
      send_atom(rand_atom());
      pause_requests(pick_gap(bursty));
    end
  endtask

  // Reset register values with zero and saturating atoms
  task automatic test_reset_values();
    send_atom(build_atom(KIND_INITIAL, 2'd0, '0, '0, '0));
    send_atom(build_atom(KIND_INITIAL, 2'd1, SAT_MAX, SAT_MAX, SAT_MAX));
    send_atom(build_atom(KIND_INITIAL, 2'd2, SAT_MIN, SAT_MIN, SAT_MIN));
    send_atom(build_atom(KIND_FINAL, 2'd3, SAT_MAX, 32'd1, '1));
  endtask

  // Largest time step against extreme reciprocal masses
  task automatic test_field_extremes();
    apply_setting(32'h0000_FFFF, '1, '0, 32'd1, INV_MASS_RST);
    send_atom(build_atom(KIND_INITIAL, 2'd0, '0, '0, SAT_MAX));
    send_atom(build_atom(KIND_INITIAL, 2'd1, '0, '0, SAT_MAX));
    send_atom(build_atom(KIND_INITIAL, 2'd2, '0, '0, SAT_MAX));
    send_atom(build_atom(KIND_INITIAL, 2'd3, '0, '0, SAT_MAX));
    send_atom(build_atom(KIND_FINAL, 2'd0, SAT_MIN, SAT_MIN, SAT_MIN));
    send_atom(build_atom(KIND_FINAL, 2'd3, SAT_MAX, SAT_MAX, SAT_MIN));
    // negative force of one ulp must floor away from zero
    send_atom(build_atom(KIND_INITIAL, 2'd0, '0, '0, '1));
  endtask

  // Zero time step: outputs follow inputs
  task automatic test_zero_time_step();
    apply_setting(32'd0, '1, '1, '1, '1);
    send_atom(build_atom(KIND_INITIAL, 2'd0, SAT_MAX, SAT_MIN, SAT_MAX));
    send_atom(build_atom(KIND_FINAL, 2'd1, SAT_MIN, SAT_MAX, SAT_MIN));
  endtask

  // Out-of-range indexes are dropped; time step keeps only its low bits
  task automatic test_register_writes();
    apply_setting(32'hABCD_0100, 32'h0002_0000, 32'h0000_8000, 32'h0010_0000,
                  32'h0000_0001);
    write_reg(3'd5, $urandom);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, '1);
    write_done();
    send_atom(build_atom(KIND_INITIAL, 2'd0, 32'h0001_0000, 32'h0004_0000, 32'h0100_0000));
    send_atom(build_atom(KIND_INITIAL, 2'd1, 32'hFFFF_0000, 32'hFFFC_0000, 32'hFF00_0000));
    send_atom(build_atom(KIND_FINAL, 2'd2, 32'h1234_5678, 32'h8765_4321, 32'h00FF_FF00));
  endtask

  // Random atoms across several register settings
  task automatic test_random_traffic();
    apply_setting({16'hFFFF, TIME_STEP_RST}, INV_MASS_RST, INV_MASS_RST, INV_MASS_RST,
                  INV_MASS_RST);
    run_random_phase(300);
    apply_setting({16'($urandom_range(65535)), 16'd0}, $urandom, $urandom, $urandom,
                  $urandom);
    run_random_phase(200);
    apply_setting(32'h0000_FFFF, '1, '1, '1, '1);
    run_random_phase(250);
    apply_setting($urandom, '0, '0, '0, '0);
    run_random_phase(150);
    apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random_phase(350);
    apply_setting($urandom_range(1023, 1), $urandom_range(32'h0010_0000, 32'h400),
                  $urandom_range(32'h0010_0000, 32'h400),
                  $urandom_range(32'h0010_0000, 32'h400),
                  $urandom_range(32'h0010_0000, 32'h400));
    run_random_phase(350);
    apply_setting($urandom, '1, '0, 32'd1, $urandom);
    run_random_phase(200);
  endtask

  // Main sequence
  initial begin
    error_count = 0;
    step_reg    = TIME_STEP_RST;
    for (int i = 0; i < NUM_TYPES; i++) inv_mass_reg[i] = INV_MASS_RST;
    rst       = 1'b1;
    start     = 1'b0;
    kind      = 1'b0;
    atom_type = '0;
    {pos_x, pos_y, pos_z}       = '0;
    {vel_x, vel_y, vel_z}       = '0;
    {force_x, force_y, force_z} = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_field_extremes();
    test_zero_time_step();
    test_register_writes();
    test_random_traffic();

    drain_pipeline();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
